FILE: rtl/bkv_pkg.sv
// ----------------------------------------------------------------------------
// bkv_pkg
// Shared types, constants and helpers for the binary key-value blob checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bkv_pkg;

    // Item carried on the input channel
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } bkv_in_t;

    // Item carried on the result channel
    typedef struct packed {
        logic       blob_valid;
        logic [2:0] error_kind;
        logic       has_nonzero_data;
    } bkv_out_t;

    // Limits handed from the register block to the parser
    typedef struct packed {
        logic [7:0]  depth_limit;
        logic [19:0] node_limit;
    } bkv_cfg_t;

    // Register port geometry
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [7:0]  DEPTH_LIMIT_RST = 8'd128;
    localparam logic [19:0] NODE_LIMIT_RST  = 20'd100000;

    // Register indexes (byte address / 4)
    typedef enum logic [0:0] {
        REG_DEPTH_LIMIT = 1'b0,
        REG_NODE_LIMIT  = 1'b1
    } bkv_reg_idx_t;

    // Type tags
    localparam logic [7:0] TAG_SECTION = 8'h00;
    localparam logic [7:0] TAG_STRING  = 8'h01;
    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_FLOAT   = 8'h03;
    localparam logic [7:0] TAG_U64     = 8'h07;
    localparam logic [7:0] TAG_END     = 8'h08;
    localparam logic [7:0] TAG_I64     = 8'h0A;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    // Fixed value lengths in bytes
    localparam logic [3:0] SHORT_VALUE_BYTES = 4'd4;
    localparam logic [3:0] LONG_VALUE_BYTES  = 4'd8;

    // Length of the watched node name
    localparam logic [2:0] DATA_NAME_LEN = 3'd4;

    typedef enum logic [2:0] {
        VK_SECTION = 3'd0,
        VK_STRING  = 3'd1,
        VK_INT     = 3'd2,
        VK_FLOAT   = 3'd3,
        VK_U64     = 3'd4,
        VK_I64     = 3'd5,
        VK_UNKNOWN = 3'd6
    } bkv_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_TRUNC = 3'd1,
        ERR_TAG   = 3'd2,
        ERR_DEEP  = 3'd3,
        ERR_NODES = 3'd4
    } bkv_err_t;

    typedef enum logic [3:0] {
        PH_TAG    = 4'b0001,
        PH_NAME   = 4'b0010,
        PH_STRING = 4'b0100,
        PH_FIXED  = 4'b1000
    } bkv_phase_t;

    // Characters of the name "data"
    function automatic logic [7:0] data_name_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h64;
            2'd1:    ch = 8'h61;
            2'd2:    ch = 8'h74;
            default: ch = 8'h61;
        endcase
        return ch;
    endfunction

    // Map a type tag onto its value kind
    function automatic bkv_kind_t tag_to_kind(input logic [7:0] tag);
        bkv_kind_t kind;
        unique case (tag)
            TAG_SECTION: kind = VK_SECTION;
            TAG_STRING:  kind = VK_STRING;
            TAG_INT:     kind = VK_INT;
            TAG_FLOAT:   kind = VK_FLOAT;
            TAG_U64:     kind = VK_U64;
            TAG_I64:     kind = VK_I64;
            default:     kind = VK_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage : bkv_pkg

`default_nettype wire

FILE: rtl/bkv_apb_regs.sv
// ----------------------------------------------------------------------------
// bkv_apb_regs
// APB register block holding the depth and node limits.
// ----------------------------------------------------------------------------
`default_nettype none

module bkv_apb_regs
    import bkv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output bkv_cfg_t                   cfg
);

    logic [7:0]   depth_limit_reg, depth_limit_next;
    logic [19:0]  node_limit_reg, node_limit_next;
    logic         wr_en;
    bkv_reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = bkv_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    // Decode the write
    always_comb begin
        depth_limit_next = depth_limit_reg;
        node_limit_next  = node_limit_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEPTH_LIMIT: depth_limit_next = pwdata[7:0];
                REG_NODE_LIMIT:  node_limit_next  = pwdata[19:0];
                default:         ;
            endcase
        end
    end

    // Hold the limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_limit_reg <= DEPTH_LIMIT_RST;
            node_limit_reg  <= NODE_LIMIT_RST;
        end else begin
            depth_limit_reg <= depth_limit_next;
            node_limit_reg  <= node_limit_next;
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_DEPTH_LIMIT: prdata = {{(CFG_DATA_W-8){1'b0}}, depth_limit_reg};
            REG_NODE_LIMIT:  prdata = {{(CFG_DATA_W-20){1'b0}}, node_limit_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.depth_limit = depth_limit_reg;
    assign cfg.node_limit  = node_limit_reg;

endmodule : bkv_apb_regs

`default_nettype wire

FILE: rtl/bkv_parser.sv
// ----------------------------------------------------------------------------
// bkv_parser
// Per-byte parse state: phase, nesting depth, node count, name match and
// running flags. One byte is taken per step; the last byte yields a verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module bkv_parser
    import bkv_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step_en,
    input  wire bkv_in_t in_item,
    input  wire bkv_cfg_t cfg,
    output bkv_out_t     result
);

    bkv_phase_t  phase_reg, phase_next;
    bkv_kind_t   kind_reg, kind_next;
    logic [7:0]  depth_reg, depth_next;
    logic [19:0] count_reg, count_next;
    logic [2:0]  match_step_reg, match_step_next;
    logic        mismatch_reg, mismatch_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic        value_nz_reg, value_nz_next;
    logic        data_nz_reg, data_nz_next;
    bkv_err_t    err_reg, err_next;
    logic        ended_reg, ended_next;

    logic [7:0]  b;
    logic [20:0] count_inc;
    logic        count_over;
    logic [8:0]  depth_inc;
    logic        depth_over;
    logic [7:0]  fixed_byte;
    logic [3:0]  fixed_left;
    logic        fixed_nz;
    bkv_err_t    verdict;
    logic        data_nz_final;

    assign b          = in_item.byte_value;
    assign count_inc  = {1'b0, count_reg} + 21'd1;
    assign count_over = count_inc > {1'b0, cfg.node_limit};
    assign depth_inc  = {1'b0, depth_reg} + 9'd1;
    assign depth_over = depth_inc > {1'b0, cfg.depth_limit};

    // Drop the float sign bit on the final value byte
    assign fixed_byte = (bytes_left_reg == 4'd1 && kind_reg == VK_FLOAT) ?
                        {1'b0, b[6:0]} : b;
    assign fixed_left = (bytes_left_reg != 4'd0) ? bytes_left_reg - 4'd1 : bytes_left_reg;
    assign fixed_nz   = value_nz_reg | (fixed_byte != NUL_BYTE);

    // Advance the parse by one byte, then clear on the last byte
    always_comb begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        match_step_next = match_step_reg;
        mismatch_next   = mismatch_reg;
        bytes_left_next = bytes_left_reg;
        value_nz_next   = value_nz_reg;
        data_nz_next    = data_nz_reg;
        err_next        = err_reg;
        ended_next      = ended_reg;
        verdict         = ERR_NONE;

        if (step_en && err_reg == ERR_NONE && !ended_reg) begin
            unique case (phase_reg)
                PH_TAG: begin
                    if (b == TAG_END) begin
                        if (depth_reg == 8'd0) begin
                            ended_next = 1'b1;
                        end else begin
                            depth_next = depth_reg - 8'd1;
                            if (count_over) begin
                                err_next = ERR_NODES;
                            end else begin
                                count_next = count_inc[19:0];
                            end
                        end
                    end else begin
                        kind_next       = tag_to_kind(b);
                        match_step_next = 3'd0;
                        mismatch_next   = 1'b0;
                        phase_next      = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (b != NUL_BYTE) begin
                        if (!mismatch_reg && match_step_reg < DATA_NAME_LEN &&
                            b == data_name_char(match_step_reg[1:0])) begin
                            match_step_next = match_step_reg + 3'd1;
                        end else begin
                            mismatch_next = 1'b1;
                        end
                    end else begin
                        if (match_step_reg != DATA_NAME_LEN) begin
                            mismatch_next = 1'b1;
                        end
                        value_nz_next = 1'b0;
                        case (kind_reg)
                            VK_SECTION: begin
                                if (depth_over) begin
                                    err_next = ERR_DEEP;
                                end else begin
                                    depth_next = depth_inc[7:0];
                                    phase_next = PH_TAG;
                                end
                            end
                            VK_STRING: phase_next = PH_STRING;
                            VK_INT, VK_FLOAT: begin
                                bytes_left_next = SHORT_VALUE_BYTES;
                                phase_next      = PH_FIXED;
                            end
                            VK_U64, VK_I64: begin
                                bytes_left_next = LONG_VALUE_BYTES;
                                phase_next      = PH_FIXED;
                            end
                            default: err_next = ERR_TAG;
                        endcase
                    end
                end
                PH_STRING: begin
                    if (b == NUL_BYTE) begin
                        value_nz_next = 1'b0;
                        if (count_over) begin
                            err_next = ERR_NODES;
                        end else begin
                            count_next = count_inc[19:0];
                        end
                        phase_next = PH_TAG;
                    end
                end
                PH_FIXED: begin
                    value_nz_next   = fixed_nz;
                    bytes_left_next = fixed_left;
                    if (fixed_left == 4'd0) begin
                        if (count_over) begin
                            err_next = ERR_NODES;
                        end else begin
                            count_next = count_inc[19:0];
                            if (!mismatch_reg && fixed_nz) begin
                                data_nz_next = 1'b1;
                            end
                        end
                        phase_next = PH_TAG;
                    end
                end
                default: ;
            endcase
        end

        // Judge the blob on its last byte
        verdict = err_next;
        if (err_next == ERR_NONE && !ended_next &&
            !(phase_next == PH_TAG && depth_next == 8'd0)) begin
            verdict = ERR_TRUNC;
        end
        data_nz_final = data_nz_next;

        if (step_en && in_item.last_byte) begin
            phase_next      = PH_TAG;
            kind_next       = VK_SECTION;
            depth_next      = 8'd0;
            count_next      = 20'd0;
            match_step_next = 3'd0;
            mismatch_next   = 1'b0;
            bytes_left_next = 4'd0;
            value_nz_next   = 1'b0;
            data_nz_next    = 1'b0;
            err_next        = ERR_NONE;
            ended_next      = 1'b0;
        end
    end

    assign result.blob_valid       = (verdict == ERR_NONE);
    assign result.error_kind       = verdict;
    assign result.has_nonzero_data = (verdict == ERR_NONE) & data_nz_final;

    // Hold the parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TAG;
            kind_reg       <= VK_SECTION;
            depth_reg      <= 8'd0;
            count_reg      <= 20'd0;
            match_step_reg <= 3'd0;
            mismatch_reg   <= 1'b0;
            bytes_left_reg <= 4'd0;
            value_nz_reg   <= 1'b0;
            data_nz_reg    <= 1'b0;
            err_reg        <= ERR_NONE;
            ended_reg      <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            match_step_reg <= match_step_next;
            mismatch_reg   <= mismatch_next;
            bytes_left_reg <= bytes_left_next;
            value_nz_reg   <= value_nz_next;
            data_nz_reg    <= data_nz_next;
            err_reg        <= err_next;
            ended_reg      <= ended_next;
        end
    end

    // A recorded error holds until the blob ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE && !(step_en && in_item.last_byte)) |=> $stable(err_reg))
        else $error("parse error code changed before the end of the blob");

    // The last byte returns the parser to its idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && in_item.last_byte) |=>
            (phase_reg == PH_TAG && depth_reg == 8'd0 && count_reg == 20'd0 &&
             err_reg == ERR_NONE && !ended_reg && !data_nz_reg))
        else $error("parse state not cleared after the last byte");

    // The blob can only end at the top level
    assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |-> (depth_reg == 8'd0))
        else $error("top-level end seen while nested");

    // The name matcher never runs past the watched name
    assert property (@(posedge aclk) disable iff (!aresetn)
        match_step_reg <= DATA_NAME_LEN)
        else $error("name match step out of range");

endmodule : bkv_parser

`default_nettype wire

FILE: rtl/binary_key_value_blob_checker.sv
// ----------------------------------------------------------------------------
// binary_key_value_blob_checker
// Streams a binary key-value blob one byte per item and returns one verdict
// item (validity, error kind, nonzero "data" flag) for the blob's last byte.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+--------------------------------
//  s_       | in        | s_valid/s_ready | byte_value, last_byte
//  m_       | out       | m_valid/m_ready | blob_valid, error_kind, has_nonzero_data
//  apb      | in        | psel/penable    | depth_limit @0x0, node_limit @0x4
//
//  One byte per cycle unless a last byte waits on a taken result slot. A byte
//  passes an input register, parse logic and, if last, the result register.
//  Reset (aresetn low, synchronous) restores the limits and clears the parser.
//  A stalled result holds the parser only when the next byte is a last byte;
//  other bytes keep flowing underneath it.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_key_value_blob_checker
    import bkv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bkv_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bkv_out_t                   m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    bkv_cfg_t cfg;
    bkv_out_t result;

    logic     in_valid_reg, in_valid_next;
    bkv_in_t  in_data_reg;
    logic     m_valid_reg, m_valid_next;
    bkv_out_t m_data_reg;
    logic     out_free;
    logic     consume;
    logic     m_load;

    bkv_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bkv_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (consume),
        .in_item (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Advance the held byte unless it needs a result slot that is taken
    assign out_free = !m_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_data_reg.last_byte || out_free);
    assign m_load   = consume && in_data_reg.last_byte;
    assign s_ready  = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (m_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A held byte that cannot advance stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("held input item lost while waiting");

    // A new result only follows a last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> in_data_reg.last_byte)
        else $error("result loaded from a byte that is not last");

    // The verdict fields agree with each other
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.blob_valid == (m_data_reg.error_kind == ERR_NONE)) &&
                         (m_data_reg.blob_valid || !m_data_reg.has_nonzero_data)))
        else $error("inconsistent verdict fields");

    // A pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !m_load)
        else $error("pending result overwritten");

endmodule : binary_key_value_blob_checker

`default_nettype wire

FILE: sim/blob_verdict_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_verdict_pkg
// Verdict tracker for the blob checker bench: replays every accepted byte
// through a running-flag parser of its own and checks each returned verdict.
// ----------------------------------------------------------------------------

package blob_verdict_pkg;

    import bkv_pkg::*;

    // Node name whose numeric value is watched, first character highest
    localparam logic [31:0] WATCH_NAME = 32'h64617461;

    class blob_verdict_tracker;

        // Limits as last written
        logic [7:0]  depth_limit;
        logic [19:0] node_limit;

        // Parser flags for the blob in flight
        bkv_phase_t  phase;
        bkv_kind_t   kind;
        logic [7:0]  depth;
        logic [19:0] nodes;
        int unsigned match_step;
        bit          name_off;
        logic [3:0]  bytes_left;
        bit          value_nz;
        bit          data_nz;
        bkv_err_t    err;
        bit          top_ended;

        bkv_out_t    pending_verdicts[$];
        int unsigned verdicts_seen;
        int unsigned errors;

        function new();
            depth_limit   = DEPTH_LIMIT_RST;
            node_limit    = NODE_LIMIT_RST;
            verdicts_seen = 0;
            errors        = 0;
            clear_blob();
        endfunction

        function void clear_blob();
            phase      = PH_TAG;
            kind       = VK_SECTION;
            depth      = '0;
            nodes      = '0;
            match_step = 0;
            name_off   = 1'b0;
            bytes_left = '0;
            value_nz   = 1'b0;
            data_nz    = 1'b0;
            err        = ERR_NONE;
            top_ended  = 1'b0;
        endfunction

        function void set_limit(bkv_reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_DEPTH_LIMIT: depth_limit = value[7:0];
                REG_NODE_LIMIT:  node_limit  = value[19:0];
                default: ;
            endcase
        endfunction

        // Count one completed node; flag the overflow and report failure
        function bit count_node();
            logic [20:0] next_count;
            next_count = {1'b0, nodes} + 21'd1;
            if (next_count > {1'b0, node_limit}) begin
                err = ERR_NODES;
                return 1'b0;
            end
            nodes = next_count[19:0];
            return 1'b1;
        endfunction

        function void finish_value();
            if (count_node() && !name_off && value_nz)
                data_nz = 1'b1;
            phase = PH_TAG;
        endfunction

        function void parse_byte(logic [7:0] b);
            logic [7:0] v;
            logic [8:0] deeper;
            v = b;
            case (phase)
                PH_TAG: begin
                    if (v == TAG_END) begin
                        // close a section, or end the blob at the top level
                        if (depth == 8'd0) begin
                            top_ended = 1'b1;
                        end else begin
                            depth = depth - 8'd1;
                            void'(count_node());
                        end
                    end else begin
                        case (v)
                            TAG_SECTION: kind = VK_SECTION;
                            TAG_STRING:  kind = VK_STRING;
                            TAG_INT:     kind = VK_INT;
                            TAG_FLOAT:   kind = VK_FLOAT;
                            TAG_U64:     kind = VK_U64;
                            TAG_I64:     kind = VK_I64;
                            default:     kind = VK_UNKNOWN;
                        endcase
                        match_step = 0;
                        name_off   = 1'b0;
                        phase      = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (v != NUL_BYTE) begin
                        // advance through the watched name while it still fits
                        if (!name_off && match_step < 4 &&
                            v == WATCH_NAME[31 - 8*match_step -: 8])
                            match_step++;
                        else
                            name_off = 1'b1;
                    end else begin
                        if (match_step != 4)
                            name_off = 1'b1;
                        value_nz = 1'b0;
                        case (kind)
                            VK_SECTION: begin
                                deeper = {1'b0, depth} + 9'd1;
                                if (deeper > {1'b0, depth_limit}) begin
                                    err = ERR_DEEP;
                                end else begin
                                    depth = deeper[7:0];
                                    phase = PH_TAG;
                                end
                            end
                            VK_STRING: phase = PH_STRING;
                            VK_INT, VK_FLOAT: begin
                                bytes_left = SHORT_VALUE_BYTES;
                                phase      = PH_FIXED;
                            end
                            VK_U64, VK_I64: begin
                                bytes_left = LONG_VALUE_BYTES;
                                phase      = PH_FIXED;
                            end
                            default: err = ERR_TAG;
                        endcase
                    end
                end
                PH_STRING: begin
                    if (v == NUL_BYTE) begin
                        value_nz = 1'b0;
                        finish_value();
                    end
                end
                default: begin
                    // drop the float sign bit on its top byte
                    if (bytes_left == 4'd1 && kind == VK_FLOAT)
                        v[7] = 1'b0;
                    if (v != NUL_BYTE)
                        value_nz = 1'b1;
                    if (bytes_left > 4'd0)
                        bytes_left = bytes_left - 4'd1;
                    if (bytes_left == 4'd0)
                        finish_value();
                end
            endcase
        endfunction

        // Replay one accepted item; a last byte yields a verdict
        function void note_byte(bkv_in_t item);
            bkv_out_t verdict;
            bkv_err_t kind_of_fault;
            if (err == ERR_NONE && !top_ended)
                parse_byte(item.byte_value);
            if (item.last_byte) begin
                kind_of_fault = err;
                if (kind_of_fault == ERR_NONE && !top_ended &&
                    !(phase == PH_TAG && depth == 8'd0))
                    kind_of_fault = ERR_TRUNC;
                verdict.blob_valid       = (kind_of_fault == ERR_NONE);
                verdict.error_kind       = kind_of_fault;
                verdict.has_nonzero_data = (kind_of_fault == ERR_NONE) && data_nz;
                pending_verdicts.insert(pending_verdicts.size(), verdict);
                clear_blob();
            end
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_verdict(bkv_out_t got);
            bkv_out_t want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("verdict %0d arrived with none pending", verdicts_seen));
            end else begin
                want = pending_verdicts.pop_front();
                if (got.blob_valid !== want.blob_valid)
                    report($sformatf("verdict %0d: blob_valid %0b, want %0b",
                                     verdicts_seen, got.blob_valid, want.blob_valid));
                if (got.error_kind !== want.error_kind)
                    report($sformatf("verdict %0d: error_kind %0d, want %0d",
                                     verdicts_seen, got.error_kind, want.error_kind));
                if (got.has_nonzero_data !== want.has_nonzero_data)
                    report($sformatf("verdict %0d: has_nonzero_data %0b, want %0b",
                                     verdicts_seen, got.has_nonzero_data,
                                     want.has_nonzero_data));
            end
            verdicts_seen++;
        endtask

        task close_out();
            if (pending_verdicts.size() != 0)
                report($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
        endtask

    endclass

endpackage : blob_verdict_pkg

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the blob checker: streams directed and random blobs, mostly well
// formed with random names and values, across several limit settings, with
// idle bursts on both channels and one long result stall, and checks every
// verdict against the tracker's own parse.
// ----------------------------------------------------------------------------

module tb_top;

    import bkv_pkg::*;
    import blob_verdict_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_T = 8'h74;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    bkv_in_t               s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    bkv_out_t              m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    blob_verdict_tracker tracker = new();

    bit          idle_on      = 1'b1;
    bit          hold_results = 1'b0;
    int unsigned quiet_cycles = 0;

    binary_key_value_blob_checker u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Note accepted bytes and check returned verdicts
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            tracker.note_byte(s_data);
        if (aresetn && m_valid && m_ready)
            tracker.check_verdict(m_data);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: idle bursts, and one long hold on request
    initial begin : result_sink
        int unsigned burst;
        @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 4);
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input bkv_in_t item);
        int unsigned burst;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            burst = $urandom_range(1, 4);
            repeat (burst) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_blob(input logic [7:0] blob[$]);
        bkv_in_t item;
        foreach (blob[i]) begin
            item.byte_value = blob[i];
            item.last_byte  = (i == blob.size() - 1);
            send_item(item);
        end
    endtask

    // Drop valid, wait for every verdict, then let the pipeline drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input bkv_reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_limit(idx, value);
    endtask

    task automatic write_limits(input logic [7:0] depth_max, input logic [19:0] node_max);
        write_reg(REG_DEPTH_LIMIT, {24'd0, depth_max});
        write_reg(REG_NODE_LIMIT, {12'd0, node_max});
    endtask

    // Append one byte to a blob under construction
    function automatic void add_byte(ref logic [7:0] blob[$], input logic [7:0] b);
        blob.insert(blob.size(), b);
    endfunction

    // Node name: mostly the watched one, else near misses or noise
    function automatic void add_name(ref logic [7:0] blob[$]);
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            for (int i = 0; i < 4; i++) add_byte(blob, WATCH_NAME[31 - 8*i -: 8]);
        end else if (pick == 5) begin
            add_byte(blob, CH_D); add_byte(blob, CH_A); add_byte(blob, CH_T);
        end else if (pick == 6) begin
            for (int i = 0; i < 4; i++) add_byte(blob, WATCH_NAME[31 - 8*i -: 8]);
            add_byte(blob, 8'($urandom_range(1, 255)));
        end else if (pick == 7) begin
            add_byte(blob, CH_D); add_byte(blob, CH_A);
            add_byte(blob, 8'($urandom_range(1, 255))); add_byte(blob, CH_A);
        end else begin
            len = $urandom_range(0, 4);
            repeat (len) add_byte(blob, 8'($urandom_range(1, 255)));
        end
        add_byte(blob, NUL_BYTE);
    endfunction

    // Fixed-width value: zero, random, one nonzero byte, or sign bit only
    function automatic void add_fixed(ref logic [7:0] blob[$], input int unsigned len);
        int unsigned mode;
        int unsigned hot;
        logic [7:0]  b;
        mode = $urandom_range(0, 3);
        hot  = $urandom_range(0, len - 1);
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'h00;
            if (mode == 1)
                b = 8'($urandom_range(0, 255));
            else if (mode == 2 && i == hot)
                b = 8'($urandom_range(1, 255));
            else if (mode == 3 && i == len - 1)
                b = 8'h80;
            add_byte(blob, b);
        end
    endfunction

    function automatic void build_blob(ref logic [7:0] blob[$], input int unsigned max_nodes);
        int unsigned node_total;
        int unsigned open_sections;
        int unsigned pick;
        int unsigned keep;
        logic [7:0]  odd_tag;
        node_total    = $urandom_range(0, max_nodes);
        open_sections = 0;
        for (int unsigned i = 0; i < node_total; i++) begin
            pick = $urandom_range(0, 19);
            if (open_sections > 0 && pick < 4) begin
                add_byte(blob, TAG_END);
                open_sections--;
            end else if (pick < 8) begin
                add_byte(blob, TAG_SECTION);
                add_name(blob);
                open_sections++;
            end else if (pick < 10) begin
                add_byte(blob, TAG_STRING);
                add_name(blob);
                repeat ($urandom_range(0, 3)) add_byte(blob, 8'($urandom_range(1, 255)));
                add_byte(blob, NUL_BYTE);
            end else if (pick < 12) begin
                add_byte(blob, TAG_INT);
                add_name(blob);
                add_fixed(blob, SHORT_VALUE_BYTES);
            end else if (pick < 14) begin
                add_byte(blob, TAG_FLOAT);
                add_name(blob);
                add_fixed(blob, SHORT_VALUE_BYTES);
            end else if (pick < 16) begin
                add_byte(blob, TAG_U64);
                add_name(blob);
                add_fixed(blob, LONG_VALUE_BYTES);
            end else if (pick < 18) begin
                add_byte(blob, TAG_I64);
                add_name(blob);
                add_fixed(blob, LONG_VALUE_BYTES);
            end else begin
                do odd_tag = 8'($urandom_range(0, 255));
                while (odd_tag inside {TAG_SECTION, TAG_STRING, TAG_INT, TAG_FLOAT,
                                       TAG_U64, TAG_END, TAG_I64});
                add_byte(blob, odd_tag);
                add_name(blob);
            end
        end
        // close open sections most of the time, then maybe end tag and trailing junk
        if ($urandom_range(0, 7) != 0)
            repeat (open_sections) add_byte(blob, TAG_END);
        if ($urandom_range(0, 1) == 0) begin
            add_byte(blob, TAG_END);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add_byte(blob, 8'($urandom_range(0, 255)));
        end
        // break a few blobs: cut short, or overwrite one byte
        pick = $urandom_range(0, 9);
        if (pick == 0 && blob.size() > 1) begin
            keep = $urandom_range(1, blob.size() - 1);
            while (blob.size() > keep) void'(blob.pop_back());
        end else if (pick == 1 && blob.size() > 0) begin
            blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if (blob.size() == 0)
            add_byte(blob, TAG_END);
    endfunction

    task automatic feed_random_blobs(input int unsigned byte_budget,
                                     input int unsigned max_nodes);
        logic [7:0]  blob[$];
        int unsigned sent;
        sent = 0;
        while (sent < byte_budget) begin
            blob.delete();
            build_blob(blob, max_nodes);
            send_blob(blob);
            sent += blob.size();
        end
    endtask

    initial begin : stimulus
        logic [7:0] blob[$];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bare end tag, nonzero int data, float minus zero data,
        // unknown tag, blob cut inside a node
        send_blob('{TAG_END});
        send_blob('{TAG_INT, CH_D, CH_A, CH_T, CH_A, NUL_BYTE,
                    8'h01, 8'h00, 8'h00, 8'h00});
        send_blob('{TAG_FLOAT, CH_D, CH_A, CH_T, CH_A, NUL_BYTE,
                    8'h00, 8'h00, 8'h00, 8'h80, TAG_END});
        send_blob('{8'hFF, NUL_BYTE});
        send_blob('{TAG_SECTION});

        // Reset limits, random blobs, then a long result stall
        feed_random_blobs(130, 6);
        hold_results = 1'b1;
        repeat (40) begin
            blob.delete();
            build_blob(blob, 0);
            send_blob(blob);
        end
        settle();

        // Lowest limits: any section or completed node fails
        write_limits(8'd0, 20'd0);
        feed_random_blobs(80, 4);
        settle();

        // Highest limits, with one nest that goes one level past the depth limit
        write_limits(8'd255, 20'hFFFFF);
        blob.delete();
        repeat (256) begin
            add_byte(blob, TAG_SECTION);
            add_byte(blob, NUL_BYTE);
        end
        send_blob(blob);
        feed_random_blobs(130, 8);
        settle();

        // Tight limits so both overflow kinds come up often
        write_limits(8'($urandom_range(1, 4)), 20'($urandom_range(1, 10)));
        feed_random_blobs(130, 8);
        settle();

        write_limits(8'($urandom_range(0, 255)), 20'($urandom_range(0, 20'hFFFFF)));
        feed_random_blobs(100, 6);
        settle();

        // Back to reset limits, no idling on either side
        write_limits(DEPTH_LIMIT_RST, NODE_LIMIT_RST);
        idle_on = 1'b0;
        feed_random_blobs(130, 6);
        settle();

        tracker.close_out();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
